@@ hw/rtl/nthp_pkg.sv @@
// Shared types and command codes for the nearest-tag heap table.
// Used by the controller, the datapath and the top level.
package nthp_pkg;

  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_PURGE  = 1'b1;

  localparam logic [1:0] ST_UPDATED  = 2'd0;
  localparam logic [1:0] ST_INSERTED = 2'd1;
  localparam logic [1:0] ST_DROPPED  = 2'd2;
  localparam logic [1:0] ST_PURGED   = 2'd3;

  localparam logic [3:0] OP_NONE     = 4'd0;
  localparam logic [3:0] OP_LOAD     = 4'd1;
  localparam logic [3:0] OP_SCAN     = 4'd2;
  localparam logic [3:0] OP_REFRESH  = 4'd3;
  localparam logic [3:0] OP_INSERT   = 4'd4;
  localparam logic [3:0] OP_REMOVE   = 4'd5;
  localparam logic [3:0] OP_SHIFT    = 4'd6;
  localparam logic [3:0] OP_SIFT     = 4'd7;
  localparam logic [3:0] OP_NEXT     = 4'd8;
  localparam logic [3:0] OP_ROOT     = 4'd9;
  localparam logic [3:0] OP_ROOTRD   = 4'd10;
  localparam logic [3:0] OP_PURGE_RD = 4'd11;
  localparam logic [3:0] OP_PURGE_CK = 4'd12;

  typedef struct packed {
    logic [3:0] op;
    logic       sift_down;
  } nthp_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic found;
    logic full;
    logic shift_done;
    logic sift_done;
    logic purge_end;
    logic expired;
    logic need_sift;
    logic dist_fell;
  } nthp_stat_t;

endpackage

@@ hw/rtl/nthp_datapath.sv @@
// Datapath of the nearest-tag heap table: entry memories, heap index arrays
// and the compare logic. Depends on nthp_pkg.
module nthp_datapath
  import nthp_pkg::*;
#(
  parameter int MAX_ENTRIES = 32,
  parameter int AW = 5,
  parameter int CW = 6
) (
  input  logic        clk,
  input  logic        rst,
  input  nthp_cmd_t   cmd,
  output nthp_stat_t  stat,
  input  logic [15:0] in_tag,
  input  logic [31:0] in_dist,
  input  logic [31:0] in_tick,
  input  logic [31:0] expire_ticks,
  output logic [CW-1:0] live_count,
  output logic [CW-1:0] removed,
  output logic [15:0] root_tag,
  output logic [31:0] root_dist,
  output logic [31:0] root_tick
);

  logic [15:0]   tag_mem  [MAX_ENTRIES];
  logic [31:0]   dist_mem [MAX_ENTRIES];
  logic [31:0]   tick_mem [MAX_ENTRIES];
  logic [AW-1:0] hpos_mem [MAX_ENTRIES];
  logic [AW-1:0] heap     [MAX_ENTRIES];
  logic [AW-1:0] order    [MAX_ENTRIES];

  logic [CW-1:0] k;
  logic [CW-1:0] j;
  logic [AW-1:0] slot;
  logic [AW-1:0] p;
  logic          sdown;
  logic          dfell;
  logic [15:0]   rd_tag;
  logic [31:0]   rd_tick;

  logic [CW:0]   lw, rw;
  logic [AW-1:0] l_i, r_i, par_i;
  logic [31:0]   dp, dl, dr, dpar;
  logic [AW-1:0] tgt;
  logic          mv;
  logic [CW-1:0] last;

  // Sift step: one compare against parent or children per cycle.
  always_comb begin
    lw    = (CW+1)'({p, 1'b1});
    rw    = lw + 1'b1;
    l_i   = lw[AW-1:0];
    r_i   = rw[AW-1:0];
    par_i = AW'((p - 1'b1) >> 1);
    dp    = dist_mem[heap[p]];
    dl    = dist_mem[heap[l_i]];
    dr    = dist_mem[heap[r_i]];
    dpar  = dist_mem[heap[par_i]];
    tgt   = p;
    mv    = 1'b0;
    if (sdown) begin
      if (lw < (CW+1)'(live_count) && dl < dp) begin
        tgt = l_i;
        mv  = 1'b1;
      end
      if (rw < (CW+1)'(live_count) && dr < (mv ? dl : dp)) begin
        tgt = r_i;
        mv  = 1'b1;
      end
    end else if (p != '0 && CW'(p) < live_count && dp < dpar) begin
      tgt = par_i;
      mv  = 1'b1;
    end
    last = live_count - 1'b1;
  end

  always_comb begin
    stat = '0;
    stat.scan_done  = k >= live_count;
    stat.found      = rd_tag == in_tag;
    stat.full       = live_count >= CW'(MAX_ENTRIES);
    stat.shift_done = ({1'b0, j} + 1'b1) >= {1'b0, live_count};
    stat.sift_done  = !mv;
    stat.purge_end  = k >= live_count;
    stat.expired    = (in_tick - rd_tick) > expire_ticks;
    stat.need_sift  = CW'(p) < live_count;
    stat.dist_fell  = dfell;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live_count <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) order[i] <= AW'(i);
    end else begin
      unique case (cmd.op)
        OP_LOAD: begin
          k       <= '0;
          removed <= '0;
        end
        OP_SCAN: begin
          slot   <= order[k[AW-1:0]];
          rd_tag <= tag_mem[order[k[AW-1:0]]];
          k      <= k + 1'b1;
        end
        OP_REFRESH: begin
          dfell          <= in_dist < dist_mem[slot];
          dist_mem[slot] <= in_dist;
          tick_mem[slot] <= in_tick;
          p              <= hpos_mem[slot];
          sdown          <= !(in_dist < dist_mem[slot]);
        end
        OP_INSERT: begin
          tag_mem[order[live_count[AW-1:0]]]  <= in_tag;
          dist_mem[order[live_count[AW-1:0]]] <= in_dist;
          tick_mem[order[live_count[AW-1:0]]] <= in_tick;
          heap[live_count[AW-1:0]]            <= order[live_count[AW-1:0]];
          hpos_mem[order[live_count[AW-1:0]]] <= live_count[AW-1:0];
          p          <= live_count[AW-1:0];
          sdown      <= 1'b0;
          live_count <= live_count + 1'b1;
        end
        OP_PURGE_RD: begin
          slot    <= order[k[AW-1:0]];
          rd_tick <= tick_mem[order[k[AW-1:0]]];
        end
        OP_PURGE_CK: k <= k + 1'b1;
        OP_REMOVE: begin
          // Drop the slot from the heap; k stays, compaction follows from j.
          p          <= hpos_mem[slot];
          sdown      <= 1'b1;
          removed    <= removed + 1'b1;
          live_count <= last;
          j          <= k;
          if (CW'(hpos_mem[slot]) < last) begin
            heap[hpos_mem[slot]]           <= heap[last[AW-1:0]];
            hpos_mem[heap[last[AW-1:0]]]   <= hpos_mem[slot];
          end
        end
        OP_SHIFT: begin
          // live_count already dropped, so the old last index is live_count.
          if (j < live_count) begin
            order[j[AW-1:0]] <= order[j[AW-1:0] + 1'b1];
            j <= j + 1'b1;
          end
        end
        OP_NEXT: begin
          order[live_count[AW-1:0]] <= slot;
          p     <= hpos_mem[slot] ;
          sdown <= 1'b1;
        end
        OP_SIFT: begin
          if (mv) begin
            heap[p]             <= heap[tgt];
            heap[tgt]           <= heap[p];
            hpos_mem[heap[p]]   <= tgt;
            hpos_mem[heap[tgt]] <= p;
            p <= tgt;
          end else if (cmd.sift_down) begin
            sdown <= 1'b0;
          end
        end
        OP_ROOT: k <= '0;
        OP_ROOTRD: begin
          root_tag  <= tag_mem[heap[0]];
          root_dist <= dist_mem[heap[0]];
          root_tick <= tick_mem[heap[0]];
        end
        default: ;
      endcase
    end
  end

endmodule

@@ hw/rtl/nthp_ctrl.sv @@
// Controller state machine of the nearest-tag heap table.
// Depends on nthp_pkg; drives the datapath by command and reads its status.
module nthp_ctrl
  import nthp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_fire,
  input  logic       in_cmd,
  input  logic       out_free,
  output logic       in_busy,
  output logic       done,
  output logic [1:0] status,
  output nthp_cmd_t  cmd,
  input  nthp_stat_t stat
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SCAN  = 4'd1;
  localparam logic [3:0] S_CHK   = 4'd2;
  localparam logic [3:0] S_REFR  = 4'd3;
  localparam logic [3:0] S_INS   = 4'd4;
  localparam logic [3:0] S_SIFT  = 4'd5;
  localparam logic [3:0] S_PRD   = 4'd6;
  localparam logic [3:0] S_PCK   = 4'd7;
  localparam logic [3:0] S_REM   = 4'd8;
  localparam logic [3:0] S_SHF   = 4'd9;
  localparam logic [3:0] S_FIX   = 4'd10;
  localparam logic [3:0] S_PSIFT = 4'd11;
  localparam logic [3:0] S_ROOT  = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;

  logic [3:0] state, state_next;
  logic [1:0] st_next;
  logic       purge, purge_next;
  logic       sdown, sdown_next;

  always_comb begin
    state_next = state;
    st_next    = status;
    purge_next = purge;
    sdown_next = sdown;
    cmd        = '0;
    cmd.sift_down = sdown;
    done       = 1'b0;
    unique case (state)
      S_IDLE: if (in_fire) begin
        cmd.op     = OP_LOAD;
        purge_next = in_cmd == CMD_PURGE;
        state_next = (in_cmd == CMD_PURGE) ? S_PRD : S_SCAN;
      end
      S_SCAN: begin
        if (stat.scan_done) state_next = stat.full ? S_ROOT : S_INS;
        else begin
          cmd.op = OP_SCAN;
          state_next = S_CHK;
        end
        if (stat.scan_done) st_next = stat.full ? ST_DROPPED : ST_INSERTED;
      end
      S_CHK: if (stat.found) begin
        st_next = ST_UPDATED;
        state_next = S_REFR;
      end else state_next = S_SCAN;
      S_REFR: begin
        cmd.op = OP_REFRESH;
        sdown_next = 1'b0;
        state_next = S_SIFT;
      end
      S_INS: begin
        cmd.op = OP_INSERT;
        sdown_next = 1'b0;
        state_next = S_SIFT;
      end
      S_SIFT: begin
        cmd.op = OP_SIFT;
        cmd.sift_down = 1'b0;
        if (stat.sift_done) state_next = S_ROOT;
      end
      S_PRD: if (stat.purge_end) begin
        st_next = ST_PURGED;
        state_next = S_ROOT;
      end else begin
        cmd.op = OP_PURGE_RD;
        state_next = S_PCK;
      end
      S_PCK: if (stat.expired) state_next = S_REM;
      else begin
        cmd.op = OP_PURGE_CK;
        state_next = S_PRD;
      end
      S_REM: begin
        cmd.op = OP_REMOVE;
        state_next = S_SHF;
      end
      S_SHF: begin
        cmd.op = OP_SHIFT;
        if (stat.shift_done) state_next = S_FIX;
      end
      S_FIX: begin
        cmd.op = OP_NEXT;
        sdown_next = 1'b1;
        state_next = S_PSIFT;
      end
      S_PSIFT: begin
        cmd.op = OP_SIFT;
        if (stat.sift_done) begin
          if (sdown) sdown_next = 1'b0;
          else state_next = S_ROOT;
        end
      end
      S_ROOT: begin
        cmd.op = OP_ROOTRD;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (purge && status == ST_PURGED) ;
        if (out_free) begin
          done = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    if (state == S_PSIFT && stat.sift_done && !sdown) begin
      // Purge continues from the same insertion index.
      state_next = S_PRD;
      cmd.op = OP_SIFT;
    end
    if (state == S_ROOT && purge) cmd.op = OP_ROOTRD;
  end

  assign in_busy = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      status <= ST_UPDATED;
      purge  <= 1'b0;
      sdown  <= 1'b0;
    end else begin
      state  <= state_next;
      status <= st_next;
      purge  <= purge_next;
      sdown  <= sdown_next;
    end
  end

endmodule

@@ hw/rtl/nearest_tag_min_heap_table_top.sv @@
// Top level of the nearest-tag heap table: controller, datapath, result
// register and the expire_ticks register. Depends on nthp_pkg.
//
//   channel | handshake            | payload
//   in      | in_valid / in_stall  | command, tag_id, distance, current_tick
//   out     | out_valid/ out_stall | status .. min_last_tick
//   cfg     | cfg_valid/ cfg_ready | cfg_data (expire_ticks)
//
// One item at a time. An update scans the ids of the live entries one by one,
// reading and then comparing each, and then takes one sift step per cycle.
// A purge reads and checks each entry in turn and, for each removal, compacts
// the insertion order and sifts the heap. Reset is synchronous and clears the
// entry count and the order list; entry memories need no clearing. The result
// waits in its register while out_stall is high and the next item is taken as
// soon as it is handed over.
module nearest_tag_min_heap_table_top
  import nthp_pkg::*;
#(
  parameter int MAX_ENTRIES = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [15:0] tag_id,
  input  logic [31:0] distance,
  input  logic [31:0] current_tick,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [5:0]  removed_count,
  output logic [5:0]  entry_count,
  output logic        min_valid,
  output logic [15:0] min_tag_id,
  output logic [31:0] min_distance,
  output logic [31:0] min_last_tick,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  logic        busy, done, in_fire, out_free;
  logic [1:0]  st;
  nthp_cmd_t   cmd;
  nthp_stat_t  stat;
  logic [31:0] expire_ticks;
  logic        cmd_q;
  logic [15:0] tag_q;
  logic [31:0] dist_q, tick_q;
  logic [CW-1:0] live, removed;
  logic [15:0] rtag;
  logic [31:0] rdist, rtick;

  assign in_stall  = busy;
  assign in_fire   = in_valid && !busy;
  assign out_free  = !out_valid || !out_stall;
  assign cfg_ready = 1'b1;

  // The incoming item is held for the whole of its processing.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_q  <= command;
      tag_q  <= tag_id;
      dist_q <= distance;
      tick_q <= current_tick;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) expire_ticks <= 32'd3000;
    else if (cfg_valid && cfg_ready) expire_ticks <= cfg_data;
  end

  nthp_ctrl u_ctrl (
    .clk, .rst, .in_fire, .in_cmd(command), .out_free,
    .in_busy(busy), .done, .status(st), .cmd, .stat
  );

  nthp_datapath #(.MAX_ENTRIES(MAX_ENTRIES), .AW(AW), .CW(CW)) u_dp (
    .clk, .rst, .cmd, .stat,
    .in_tag(tag_q), .in_dist(dist_q), .in_tick(tick_q),
    .expire_ticks, .live_count(live), .removed,
    .root_tag(rtag), .root_dist(rdist), .root_tick(rtick)
  );

  // Result register: an empty table reports zeros for the root fields.
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (done) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
    if (done) begin
      status        <= st;
      removed_count <= (cmd_q == CMD_PURGE) ? 6'(removed) : 6'd0;
      entry_count   <= 6'(live);
      min_valid     <= live != '0;
      min_tag_id    <= (live != '0) ? rtag  : 16'd0;
      min_distance  <= (live != '0) ? rdist : 32'd0;
      min_last_tick <= (live != '0) ? rtick : 32'd0;
    end
  end

endmodule

@@ hw/rtl/nthp_checker.sv @@
// Port-level checker for the nearest-tag heap table, bound to the top level.
// Depends on the top-level ports and nthp_pkg.
module nthp_checker
  import nthp_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  status,
  input logic [5:0]  removed_count,
  input logic [5:0]  entry_count,
  input logic        min_valid
);

  a_minv: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (min_valid == (entry_count != 6'd0))) else $error("min_valid");
  a_rem: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_PURGED |-> removed_count == 6'd0) else $error("removed");
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> entry_count <= 6'd32) else $error("count");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status)) else $error("hold");
  // An accepted item keeps the block busy on the following cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall) else $error("busy");

endmodule

bind nearest_tag_min_heap_table_top nthp_checker u_chk (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall,
  .status, .removed_count, .entry_count, .min_valid
);
